// File: hdl/gcdisp_pkg.sv
// ----------------------------------------------------------------------------
// Change dispenser package
// Widths, denomination tables, reciprocal constants and the beat type that
// runs down the chain of denomination cells.
// ----------------------------------------------------------------------------
package gcdisp_pkg;

  localparam int unsigned AMOUNT_BITS = 20;
  localparam int unsigned STOCK_BITS  = 8;
  localparam int unsigned DENOM_COUNT = 7;

  localparam int unsigned IDX_BITS  = $clog2(DENOM_COUNT);
  localparam int unsigned CMP_BITS  = (AMOUNT_BITS > STOCK_BITS) ? AMOUNT_BITS : STOCK_BITS;
  localparam int unsigned RECIP_BITS = AMOUNT_BITS + 1;
  localparam int unsigned PROD_BITS  = AMOUNT_BITS + RECIP_BITS;

  localparam int unsigned IN_DATA_BITS  = ((AMOUNT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = DENOM_COUNT * STOCK_BITS + AMOUNT_BITS;
  localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [STOCK_BITS-1:0] STOCK_MAX = {STOCK_BITS{1'b1}};

  typedef logic [IDX_BITS-1:0] denom_idx_t;

  // Largest denomination first, in centavos.
  localparam int unsigned DENOM_VALUE [DENOM_COUNT] = '{
    20000, 10000, 5000, 1000, 500, 100, 50
  };

  localparam logic [STOCK_BITS-1:0] STOCK_RESET [DENOM_COUNT] = '{
    STOCK_BITS'(2), STOCK_BITS'(4), STOCK_BITS'(6), STOCK_BITS'(10),
    STOCK_BITS'(10), STOCK_BITS'(20), STOCK_BITS'(20)
  };

  // floor(x / v) = (x * ceil(2^s / v)) >> s for every x below 2^AMOUNT_BITS
  // when s = AMOUNT_BITS + clog2(v).
  localparam int unsigned RECIP_SHIFT [DENOM_COUNT] = '{
    AMOUNT_BITS + $clog2(20000), AMOUNT_BITS + $clog2(10000),
    AMOUNT_BITS + $clog2(5000),  AMOUNT_BITS + $clog2(1000),
    AMOUNT_BITS + $clog2(500),   AMOUNT_BITS + $clog2(100),
    AMOUNT_BITS + $clog2(50)
  };

  localparam logic [RECIP_BITS-1:0] RECIP [DENOM_COUNT] = '{
    RECIP_BITS'(((64'd1 << RECIP_SHIFT[0]) + 64'(DENOM_VALUE[0]) - 64'd1)
                / 64'(DENOM_VALUE[0])),
    RECIP_BITS'(((64'd1 << RECIP_SHIFT[1]) + 64'(DENOM_VALUE[1]) - 64'd1)
                / 64'(DENOM_VALUE[1])),
    RECIP_BITS'(((64'd1 << RECIP_SHIFT[2]) + 64'(DENOM_VALUE[2]) - 64'd1)
                / 64'(DENOM_VALUE[2])),
    RECIP_BITS'(((64'd1 << RECIP_SHIFT[3]) + 64'(DENOM_VALUE[3]) - 64'd1)
                / 64'(DENOM_VALUE[3])),
    RECIP_BITS'(((64'd1 << RECIP_SHIFT[4]) + 64'(DENOM_VALUE[4]) - 64'd1)
                / 64'(DENOM_VALUE[4])),
    RECIP_BITS'(((64'd1 << RECIP_SHIFT[5]) + 64'(DENOM_VALUE[5]) - 64'd1)
                / 64'(DENOM_VALUE[5])),
    RECIP_BITS'(((64'd1 << RECIP_SHIFT[6]) + 64'(DENOM_VALUE[6]) - 64'd1)
                / 64'(DENOM_VALUE[6]))
  };

  typedef struct packed {
    logic [AMOUNT_BITS-1:0]                  rest;
    logic [DENOM_COUNT-1:0][STOCK_BITS-1:0]  counts;
  } beat_t;

  typedef struct packed {
    logic  valid;
    beat_t beat;
  } link_t;

endpackage

// File: hdl/gcdisp_cell.sv
// ----------------------------------------------------------------------------
// Denomination cell
// Holds the stock of one denomination. The first stage finds how many of it
// fit into the remaining amount; the second pays out the lesser of that and
// the stock, and hands the rest to the next cell.
// ----------------------------------------------------------------------------
module gcdisp_cell
  import gcdisp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  denom_idx_t cell_idx_i,
  input  link_t      up_i,
  output logic       up_ready_o,
  output link_t      dn_o,
  input  logic       dn_ready_i
);

  logic                   va_q;
  logic [STOCK_BITS-1:0]  qa_q, qa_d;
  beat_t                  beat_a_q;

  logic                   vb_q;
  beat_t                  beat_b_q, beat_b_d;

  logic [STOCK_BITS-1:0]  spent_q, spent_d;
  logic [STOCK_BITS-1:0]  stock;
  logic [STOCK_BITS-1:0]  take;

  logic                   ready_a, ready_b;
  logic [PROD_BITS-1:0]   prod;
  logic [AMOUNT_BITS-1:0] q_full;

  assign ready_b    = !vb_q || dn_ready_i;
  assign ready_a    = !va_q || ready_b;
  assign up_ready_o = ready_a;

  always_comb begin
    prod   = PROD_BITS'(up_i.beat.rest) * PROD_BITS'(RECIP[cell_idx_i]);
    q_full = AMOUNT_BITS'(prod >> RECIP_SHIFT[cell_idx_i]);
    // Anything past the largest stock count is capped; stock can never reach it.
    if (CMP_BITS'(q_full) > CMP_BITS'(STOCK_MAX)) begin
      qa_d = STOCK_MAX;
    end else begin
      qa_d = STOCK_BITS'(q_full);
    end
  end

  always_comb begin
    stock    = STOCK_RESET[cell_idx_i] - spent_q;
    take     = (qa_q < stock) ? qa_q : stock;
    spent_d  = spent_q + take;
    beat_b_d = beat_a_q;
    beat_b_d.rest = beat_a_q.rest
                    - AMOUNT_BITS'(32'(take) * DENOM_VALUE[cell_idx_i]);
    beat_b_d.counts[cell_idx_i] = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      spent_q <= '0;
    end else begin
      if (ready_a) begin
        va_q <= up_i.valid;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
      if (va_q && ready_b) begin
        spent_q <= spent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_i.valid && ready_a) begin
      qa_q     <= qa_d;
      beat_a_q <= up_i.beat;
    end
    if (va_q && ready_b) begin
      beat_b_q <= beat_b_d;
    end
  end

  assign dn_o.valid = vb_q;
  assign dn_o.beat  = beat_b_q;

endmodule

// File: hdl/greedy_change_dispenser.sv
// ----------------------------------------------------------------------------
// Greedy change dispenser
// Pays each change amount out from the largest denomination down, limited by
// the stock of each denomination, and reports the counts and the unpaid rest.
// ----------------------------------------------------------------------------
// Channel  Direction  Beat content
// s_*      in         one change amount
// m_*      out        seven payout counts and the unpaid amount
//
// One beat per cycle is taken and delivered in steady flow. Each amount
// passes seven cells, one per denomination, each with a quotient stage
// (reciprocal multiply) and a payout stage, so it passes 14 registers and
// the first loads at the accept. Reset restores all stock at once.
// While m_tready_i is low the last stage holds its result and upstream
// stages keep filling empty slots; s_tready_o falls only when all 14
// stages hold beats.
// ----------------------------------------------------------------------------
module greedy_change_dispenser
  import gcdisp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_tvalid_i,
  output logic                     s_tready_o,
  input  logic [IN_DATA_BITS-1:0]  s_tdata_i,  // amount_cents, zero padding
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  // count_note_200, count_note_100, count_note_50, count_note_10, count_note_5,
  // count_coin_100c, count_coin_50c, unpaid_cents, zero padding
  output logic [OUT_DATA_BITS-1:0] m_tdata_o
);

  link_t links [DENOM_COUNT+1];
  logic  readies [DENOM_COUNT+1];

  assign links[0].valid       = s_tvalid_i;
  assign links[0].beat.rest   = s_tdata_i[AMOUNT_BITS-1:0];
  assign links[0].beat.counts = '0;
  assign s_tready_o           = readies[0];

  for (genvar i = 0; i < DENOM_COUNT; i++) begin : g_cell
    gcdisp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (denom_idx_t'(i)),
      .up_i       (links[i]),
      .up_ready_o (readies[i]),
      .dn_o       (links[i+1]),
      .dn_ready_i (readies[i+1])
    );
  end

  assign readies[DENOM_COUNT] = m_tready_i;
  assign m_tvalid_o = links[DENOM_COUNT].valid;
  assign m_tdata_o  = OUT_DATA_BITS'({links[DENOM_COUNT].beat.rest,
                                      links[DENOM_COUNT].beat.counts});

endmodule

// File: hdl/gcdisp_checker.sv
// ----------------------------------------------------------------------------
// Change dispenser checker
// Port-level assertions on both streams, bound to the top level.
// ----------------------------------------------------------------------------
module gcdisp_checker
  import gcdisp_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_tvalid_i,
  input logic                     s_tready_o,
  input logic [IN_DATA_BITS-1:0]  s_tdata_i,
  input logic                     m_tvalid_o,
  input logic                     m_tready_i,
  input logic [OUT_DATA_BITS-1:0] m_tdata_o
);

  logic counts_in_stock;

  // No denomination can ever pay more than it held after reset.
  always_comb begin
    counts_in_stock = 1'b1;
    for (int i = 0; i < DENOM_COUNT; i++) begin
      if (m_tdata_o[i*STOCK_BITS +: STOCK_BITS] > STOCK_RESET[i]) begin
        counts_in_stock = 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result beat changed while stalled");

  a_counts_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> counts_in_stock)
    else $error("payout count exceeds initial stock");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o >> OUT_FIELD_BITS) == '0)
    else $error("result padding bits not zero");

  // A result needs at least one accepted amount and a full trip down the chain.
  a_no_early_result: assert property (@(posedge clk_i)
    !rst_ni |=> !m_tvalid_o)
    else $error("result beat right after reset");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && !s_tready_o |=> s_tvalid_i && $stable(s_tdata_i))
    else $error("amount beat changed while waiting");

endmodule

bind greedy_change_dispenser gcdisp_checker u_gcdisp_checker (.*);
